// File: hdl/sbmq_pkg.sv
// Shared types and codes for the shared-buffer multi-queue manager.
// No dependencies; imported by the top level, sbmq_ctrl and sbmq_dp.
package sbmq_pkg;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic               req_type;
        logic [1:0]         queue_id;
        logic signed [31:0] key;
    } req_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;    // request accepted: latch it, read head/tail
        logic fetch;   // read link/data of the selected slot, store push key
        logic commit;  // update pointers, load the response register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;  // response register can take a new result
    } sts_t;

endpackage

// File: hdl/shared_buffer_multi_queue.sv
// Shared-buffer multi-queue manager: top level.
// Depends on sbmq_pkg, sbmq_ctrl, sbmq_dp (which uses sbmq_ram).
//
// QUEUES FIFO queues share a pool of SLOTS 32-bit slots, linked through a
// next-pointer RAM; unused slots form a free list.
// Request channel (req_valid/req_ready/req): push key onto queue_id, or pop
// from queue_id. queue_id wraps modulo QUEUES.
// Response channel (rsp_valid/rsp_ready/rsp): one response per request, in
// order. Push: status ok, or full (request dropped). Pop: popped key and ok,
// or data 0 with status empty.
// Sequence: a request passes through load, which reads the queue's
// head/tail RAMs, fetch, which reads the slot's link and data RAMs, and
// commit, which writes back the pointers and loads the response register;
// a new request is taken only after commit. Each RAM has a registered read port.
// A finished response waits in the output register; the next request is
// accepted and worked on meanwhile and only holds in its write-back cycle
// until the waiting response is taken.
// Reset: all queues empty, every slot free. The link RAM needs no clearing
// pass; slots never yet handed out are tracked by a fill count.
module shared_buffer_multi_queue
    import sbmq_pkg::*;
#(
    parameter int SLOTS  = 16,
    parameter int QUEUES = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: one request in flight
    sbmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // list storage, pointers and response register
    sbmq_dp #(.SLOTS(SLOTS), .QUEUES(QUEUES)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    // an accepted request keeps the block busy for its fetch and commit cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready ##1 !req_ready)
        else $error("request accepted while previous one still in progress");

    // failed requests never carry data
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_OK)) |-> (rsp.data == '0))
        else $error("full or empty response with nonzero data");

    // status is always one of the three defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_FULL
                       || rsp.status == ST_EMPTY))
        else $error("undefined response status");
`endif

endmodule

// File: hdl/sbmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sbmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/sbmq_ctrl.sv
// Request sequencer: idle -> fetch -> commit, holding in commit while the
// response register is occupied. Depends on sbmq_pkg.
module sbmq_ctrl
    import sbmq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_FETCH  = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/sbmq_dp.sv
// Datapath: slot data/link RAMs, per-queue head/tail RAMs, free list
// pointers and the response register. Depends on sbmq_pkg, sbmq_ram.
module sbmq_dp
    import sbmq_pkg::*;
#(
    parameter int SLOTS  = 16,
    parameter int QUEUES = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int IW = $clog2(SLOTS);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int FW = $clog2(SLOTS + 1);
    localparam int LW = IW + 1;

    // queue_id wraps modulo QUEUES
    localparam logic [QW-1:0] QMAP [4] = '{QW'(0 % QUEUES), QW'(1 % QUEUES),
                                           QW'(2 % QUEUES), QW'(3 % QUEUES)};

    logic               op_reg;
    logic [QW-1:0]      q_reg;
    logic [31:0]        key_reg;

    logic [IW-1:0]      free_head_reg;
    logic [IW-1:0]      free_head_next;
    logic               free_valid_reg;
    logic               free_valid_next;
    logic [FW-1:0]      fresh_reg;       // slots >= fresh_reg still on the initial chain
    logic [FW-1:0]      fresh_next;
    logic [QUEUES-1:0]  head_valid_reg;
    logic [QUEUES-1:0]  head_valid_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic               head_we;
    logic [IW-1:0]      head_wd;
    logic [IW-1:0]      head_rd;
    logic               tail_we;
    logic [IW-1:0]      tail_rd;
    logic               link_we;
    logic [IW-1:0]      link_wa;
    logic [LW-1:0]      link_wd;
    logic [IW-1:0]      link_ra;
    logic [LW-1:0]      link_rd;
    logic               data_we;
    logic               data_re;
    logic [31:0]        data_rd;

    logic               q_valid;
    logic               s_fresh;
    logic               fresh_last;
    logic [FW-1:0]      fresh_inc;

    sbmq_ram #(.WIDTH(IW), .DEPTH(QUEUES)) u_head_ram (
        .clk     (clk),
        .wr_en   (head_we),
        .wr_addr (q_reg),
        .wr_data (head_wd),
        .rd_en   (cmd.load),
        .rd_addr (QMAP[req.queue_id]),
        .rd_data (head_rd)
    );

    sbmq_ram #(.WIDTH(IW), .DEPTH(QUEUES)) u_tail_ram (
        .clk     (clk),
        .wr_en   (tail_we),
        .wr_addr (q_reg),
        .wr_data (free_head_reg),
        .rd_en   (cmd.load),
        .rd_addr (QMAP[req.queue_id]),
        .rd_data (tail_rd)
    );

    sbmq_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
        .clk     (clk),
        .wr_en   (link_we),
        .wr_addr (link_wa),
        .wr_data (link_wd),
        .rd_en   (cmd.fetch),
        .rd_addr (link_ra),
        .rd_data (link_rd)
    );

    sbmq_ram #(.WIDTH(32), .DEPTH(SLOTS)) u_data_ram (
        .clk     (clk),
        .wr_en   (data_we),
        .wr_addr (free_head_reg),
        .wr_data (key_reg),
        .rd_en   (data_re),
        .rd_addr (head_rd),
        .rd_data (data_rd)
    );

    assign link_ra = (op_reg == REQ_PUSH) ? free_head_reg : head_rd;
    assign data_we = cmd.fetch && (op_reg == REQ_PUSH) && free_valid_reg;
    assign data_re = cmd.fetch && (op_reg == REQ_POP);

    assign q_valid    = head_valid_reg[q_reg];
    assign s_fresh    = (FW'(free_head_reg) == fresh_reg);
    assign fresh_inc  = fresh_reg + FW'(1);
    assign fresh_last = (fresh_reg == FW'(SLOTS - 1));

    always_comb
    begin
        head_we         = 1'b0;
        head_wd         = free_head_reg;
        tail_we         = 1'b0;
        link_we         = 1'b0;
        link_wa         = free_head_reg;
        link_wd         = {free_valid_reg, free_head_reg};
        free_head_next  = free_head_reg;
        free_valid_next = free_valid_reg;
        fresh_next      = fresh_reg;
        head_valid_next = head_valid_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_ready ? 1'b0 : rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
            rsp_next.data   = '0;
            rsp_next.status = ST_OK;
            if (op_reg == REQ_PUSH)
            begin
                if (!free_valid_reg)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    tail_we = 1'b1;
                    if (q_valid)
                    begin
                        link_we = 1'b1;
                        link_wa = tail_rd;
                        link_wd = {1'b1, free_head_reg};
                    end
                    else
                    begin
                        head_we                = 1'b1;
                        head_valid_next[q_reg] = 1'b1;
                    end
                    if (s_fresh)
                    begin
                        free_head_next  = IW'(fresh_inc);
                        free_valid_next = !fresh_last;
                        fresh_next      = fresh_inc;
                    end
                    else
                    begin
                        free_head_next  = link_rd[IW-1:0];
                        free_valid_next = link_rd[IW];
                    end
                end
            end
            else
            begin
                if (!q_valid)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    if (head_rd == tail_rd)
                    begin
                        head_valid_next[q_reg] = 1'b0;
                    end
                    else
                    begin
                        head_we = 1'b1;
                        head_wd = link_rd[IW-1:0];
                    end
                    link_we         = 1'b1;
                    link_wa         = head_rd;
                    link_wd         = {free_valid_reg, free_head_reg};
                    free_head_next  = head_rd;
                    free_valid_next = 1'b1;
                    rsp_next.data   = data_rd;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg  <= '0;
            free_valid_reg <= 1'b1;
            fresh_reg      <= '0;
            head_valid_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            free_head_reg  <= free_head_next;
            free_valid_reg <= free_valid_next;
            fresh_reg      <= fresh_next;
            head_valid_reg <= head_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.req_type;
            q_reg   <= QMAP[req.queue_id];
            key_reg <= req.key;
        end
        rsp_reg <= rsp_next;
    end

    assign sts.out_free = !rsp_valid_reg || rsp_ready;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;

endmodule
